>>> hdl/sida_pkg.sv
// shared constants, types and helpers for the signed integer to decimal ascii block
// used by sida_ctrl, sida_dpath and the top level; no dependencies
package sida_pkg;

  localparam int VAL_W         = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP = 2;
  localparam int CONV_STEPS    = VAL_W / BITS_PER_STEP;
  localparam int CNT_W         = $clog2(CONV_STEPS);
  localparam int IDX_W         = $clog2(NUM_DIGITS);
  localparam int CHAR_W        = 8;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture magnitude and sign, clear bcd
    logic step;        // one double-dabble step
    logic scan;        // latch index of leading digit
    logic next_digit;  // move to next lower digit
    logic sel_sign;    // drive minus sign on the output
  } sida_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic neg;
    logic idx_zero;
  } sida_sts_t;

  // one shift-and-add-3 step over the bcd and binary words
  function automatic logic [BCD_W+VAL_W-1:0] dd_bit(input logic [BCD_W+VAL_W-1:0] w);
    logic [BCD_W-1:0] b;
    b = w[BCD_W+VAL_W-1:VAL_W];
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        b[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return {b[BCD_W-2:0], w[VAL_W-1:0], 1'b0};
  endfunction

endpackage

>>> hdl/sida_ctrl.sv
// controller state machine: conversion step count and character sequencing
// depends on sida_pkg
module sida_ctrl import sida_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  sida_sts_t sts,
  output sida_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = sts.neg ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        cmd.sel_sign = 1'b1;
        if (out_ready) begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_ready) begin
          if (sts.idx_zero) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.next_digit = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_SIGN) || (state_r == ST_DIGIT);

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while characters pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready && !out_valid)
    else $error("conversion did not start after accept");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT && out_ready && sts.idx_zero) |=> in_ready)
    else $error("block not idle after last character");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_CONV) |-> (cnt_r == '0))
    else $error("step counter not cleared outside conversion");
`endif

endmodule

>>> hdl/sida_dpath.sv
// datapath: magnitude, double-dabble bcd conversion, leading digit search, char select
// depends on sida_pkg
module sida_dpath import sida_pkg::*; (
  input  logic              clk,
  input  logic signed [VAL_W-1:0] in_value,
  input  sida_cmd_t         cmd,
  output sida_sts_t         sts,
  output logic [CHAR_W-1:0] char_code,
  output logic              is_last
);

  logic [VAL_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic             neg_r, neg_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [BCD_W+VAL_W-1:0] w1, w2;
  logic [IDX_W-1:0]       lead;
  logic [3:0]             digs [NUM_DIGITS];
  logic [3:0]             digit;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      digs[i] = bcd_r[4*i +: 4];
    end
  end

  // highest nonzero digit, zero when the whole number is zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digs[i] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  assign w1 = dd_bit({bcd_r, bin_r});
  assign w2 = dd_bit(w1);

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    idx_nxt = idx_r;
    if (cmd.load) begin
      neg_nxt = in_value[VAL_W-1];
      // unsigned negate keeps the most negative value exact
      bin_nxt = in_value[VAL_W-1] ? (VAL_W'(0) - VAL_W'(in_value)) : VAL_W'(in_value);
      bcd_nxt = '0;
    end
    if (cmd.step) begin
      bcd_nxt = w2[BCD_W+VAL_W-1:VAL_W];
      bin_nxt = w2[VAL_W-1:0];
    end
    if (cmd.scan) begin
      idx_nxt = lead;
    end
    if (cmd.next_digit) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
    idx_r <= idx_nxt;
  end

  assign digit     = digs[idx_r];
  assign char_code = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, digit});
  assign is_last   = !cmd.sel_sign && (idx_r == '0);

  assign sts.neg      = neg_r;
  assign sts.idx_zero = (idx_r == '0);

endmodule

>>> hdl/signed_int_to_decimal_ascii.sv
// top level of the signed integer to decimal ascii formatter
// depends on sida_pkg, sida_ctrl and sida_dpath
//
// usage:
//   input channel: in_value (signed 32 bit) with in_valid / in_ready
//   output channel: out_char_code (ascii) and out_is_last with out_valid / out_ready
//   each input item gives its decimal text, most significant character first:
//   a '-' for negative values, then the digits without leading zeros ('0' for zero);
//   out_is_last marks the final character of each number
// timing:
//   after accept, double-dabble conversion runs in ST_CONV (two bits per cycle)
//   and ST_SCAN finds the leading digit; the first character is shown
//   once ST_SCAN is done, then one character per cycle while out_ready is high
//   an item gives n = 1..11 characters; one item at a time,
//   in_ready is high only when no characters are pending
// reset: synchronous active-low rst_n returns the controller to idle, no output pending
// stall: while out_ready is low the current character holds and the sequence waits
module signed_int_to_decimal_ascii import sida_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAR_W-1:0]       out_char_code,
  output logic                    out_is_last
);

  sida_cmd_t cmd;
  sida_sts_t sts;

  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sida_dpath u_dpath (
    .clk       (clk),
    .in_value  (in_value),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (out_char_code),
    .is_last   (out_is_last)
  );

endmodule

>>> bench/signed_int_to_decimal_ascii_tb.sv
// testbench for signed_int_to_decimal_ascii: predicts the ascii text of each integer
// and checks every character and last flag in order; depends on sida_pkg and the rtl
module signed_int_to_decimal_ascii_tb;
  import sida_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  // margin for the conversion and the at most 11 characters of a last item
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } text_char_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [CHAR_W-1:0]       out_char_code;
  logic                    out_is_last;

  text_char_t pending_chars[$];
  text_char_t want;
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         hold_cycles = 0;
  bit         calm = 1'b0;

  signed_int_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char_code (out_char_code),
    .out_is_last   (out_is_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("signed_int_to_decimal_ascii_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $error("char_code: no character expected, got %0d", out_char_code);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char_code !== want.char_code) begin
          $error("char_code: expected %0d, got %0d", want.char_code, out_char_code);
          mismatch_count++;
        end
        if (out_is_last !== want.is_last) begin
          $error("is_last: expected %0d, got %0d", want.is_last, out_is_last);
          mismatch_count++;
        end
      end
    end
  end

  // sign first, then digits of the unsigned magnitude without leading zeros
  function automatic void queue_decimal_text(input logic signed [VAL_W-1:0] v);
    logic [VAL_W-1:0] mag;
    logic [3:0]       digs[NUM_DIGITS];
    int               n;
    mag = v;
    if (v[VAL_W-1]) begin
      mag = ~mag + 1'b1;
      pending_chars.push_back('{char_code: CHAR_MINUS, is_last: 1'b0});
    end
    n = 0;
    do begin
      digs[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    for (int i = n - 1; i >= 0; i--) begin
      pending_chars.push_back('{char_code: CHAR_ZERO + CHAR_W'(digs[i]), is_last: i == 0});
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] top;
    logic [VAL_W-1:0] mag;
    int               k;
    k = $urandom_range(1, 9);
    top = 1;
    repeat (k) top = top * 10;
    case ($urandom_range(3))
      0: return $urandom;
      1: mag = $urandom_range(top - 1);
      2: mag = top + $urandom_range(2) - 1;
      default: begin
        // near either end of the range
        if ($urandom_range(1)) return 32'h7fffffff - $urandom_range(20);
        return 32'h80000000 + $urandom_range(20);
      end
    endcase
    if ($urandom_range(1)) mag = ~mag + 1'b1;
    return mag;
  endfunction

  // called right after a rising edge; returns at the edge that accepts the item
  task automatic send_value(input logic signed [VAL_W-1:0] v);
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_decimal_text(v);
  endtask

  task automatic wait_text_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_values();
    logic signed [VAL_W-1:0] corners[20] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
      999999999, 1000000000, -1000000000, 1999999999,
      32'h7fffffff, 32'h80000001, 32'h80000000,
      32'h55555555, 32'haaaaaaaa, 7
    };
    foreach (corners[i]) send_value(corners[i]);
  endtask

  task automatic test_random_values();
    repeat (95) send_value(pick_value());
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_output_backpressure();
    hold_cycles = 300;
    repeat (15) send_value(pick_value());
  endtask

  task automatic test_drain_between_items();
    repeat (5) begin
      send_value(pick_value());
      send_value(pick_value());
      wait_text_drained();
      @(posedge clk);
    end
  endtask

  task automatic test_full_rate();
    calm = 1'b1;
    repeat (30) send_value(pick_value());
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_values();
    test_random_values();
    test_output_backpressure();
    test_drain_between_items();
    test_full_rate();
    wait_text_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("char_code: %0d characters never arrived", pending_chars.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("signed_int_to_decimal_ascii_tb OK");
    end else begin
      $display("signed_int_to_decimal_ascii_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> signed_int_to_decimal_ascii.f
hdl/sida_pkg.sv
hdl/sida_ctrl.sv
hdl/sida_dpath.sv
hdl/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_tb.sv
